// ===== hdl/cubic_bezier_flattener_defines.svh =====
// assertion macros used by the sample sequencer of the cubic bezier flattener
`ifndef CUBIC_BEZIER_FLATTENER_DEFINES_SVH
`define CUBIC_BEZIER_FLATTENER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CBF_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CBF_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/cbf_pkg.sv =====
// types, constants and the interpolation function of the bezier flattener
`timescale 1ns / 1ps
package cbf_pkg;

	localparam int STEPS_LOG2 = 5;
	localparam int COORD_BITS = 16;
	localparam int STEP_BITS  = STEPS_LOG2 + 1;
	localparam int SUM_BITS   = COORD_BITS + STEPS_LOG2 + 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t LAST_STEP = step_t'(1 << STEPS_LOG2);

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	// sample request from the sequencer to the interpolation pipeline
	typedef struct packed {
		logic       valid;
		step_t      step;
		point_t [3:0] pts;
	} issue_t;

	// floor((a*(N-j) + b*j) / N), exact since N is a power of two
	function automatic coord_t lerp(input coord_t a, input coord_t b, input step_t j);
		logic signed [SUM_BITS-1:0] wa;
		logic signed [SUM_BITS-1:0] wb;
		logic signed [SUM_BITS-1:0] ka;
		logic signed [SUM_BITS-1:0] kb;
		logic signed [SUM_BITS-1:0] s;
		logic signed [SUM_BITS-1:0] sh;
		wa = SUM_BITS'(a);
		wb = SUM_BITS'(b);
		ka = SUM_BITS'(step_t'(LAST_STEP - j));
		kb = SUM_BITS'(j);
		s  = wa * ka + wb * kb;
		sh = s >>> STEPS_LOG2;
		return sh[COORD_BITS-1:0];
	endfunction

	function automatic point_t lerp_pt(input point_t a, input point_t b, input step_t j);
		point_t r;
		r.x = lerp(a.x, b.x, j);
		r.y = lerp(a.y, b.y, j);
		return r;
	endfunction

endpackage

// ===== hdl/cubic_bezier_flattener.sv =====
// Cubic bezier flattener: each accepted segment (start, two controls, end,
// signed Q2.14) yields 33 samples at t = j/32, j = 0..32, the first being the
// start point and the last, flagged by last_point, the end point. Samples
// leave at one per cycle while the output is not stalled; the next segment is
// accepted in the cycle its predecessor's final sample is issued, so segments
// stream with no gap. The rate is set by the single sample sequencer; an issued
// sample passes one pipeline stage per de casteljau level, the last of them
// being the output register. An output stall while out_valid is high freezes
// the whole pipeline.
`timescale 1ns / 1ps
module cubic_bezier_flattener (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  cbf_pkg::coord_t  start_x,
	input  cbf_pkg::coord_t  start_y,
	input  cbf_pkg::coord_t  ctrl_a_x,
	input  cbf_pkg::coord_t  ctrl_a_y,
	input  cbf_pkg::coord_t  ctrl_b_x,
	input  cbf_pkg::coord_t  ctrl_b_y,
	input  cbf_pkg::coord_t  end_x,
	input  cbf_pkg::coord_t  end_y,
	output logic             out_valid,
	input  logic             out_stall,
	output cbf_pkg::coord_t  out_x,
	output cbf_pkg::coord_t  out_y,
	output logic             last_point
);
	import cbf_pkg::*;

	point_t [3:0] seg_in;
	issue_t       issue;
	logic         adv;

	// gather the segment into control points
	always_comb begin
		seg_in[0].x = start_x;
		seg_in[0].y = start_y;
		seg_in[1].x = ctrl_a_x;
		seg_in[1].y = ctrl_a_y;
		seg_in[2].x = ctrl_b_x;
		seg_in[2].y = ctrl_b_y;
		seg_in[3].x = end_x;
		seg_in[3].y = end_y;
	end

	// pipeline advances unless a held result is stalled
	assign adv = !(out_valid && out_stall);

	cbf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.seg_in   (seg_in),
		.adv      (adv),
		.issue    (issue)
	);

	cbf_casteljau u_casteljau (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.adv        (adv),
		.out_valid  (out_valid),
		.out_x      (out_x),
		.out_y      (out_y),
		.last_point (last_point)
	);

endmodule

// ===== hdl/cbf_seq.sv =====
// segment latch and sample sequencer
`timescale 1ns / 1ps
`include "cubic_bezier_flattener_defines.svh"
module cbf_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  cbf_pkg::point_t [3:0]   seg_in,
	input  logic                    adv,
	output cbf_pkg::issue_t         issue
);
	import cbf_pkg::*;

	logic         busy_q;
	step_t        step_q;
	point_t [3:0] seg_q;
	logic         accept;
	logic         final_issue;

	// a new segment is taken while idle or as the last sample of the current one issues
	assign final_issue = busy_q && adv && (step_q == LAST_STEP);
	assign in_stall    = busy_q && !final_issue;
	assign accept      = in_valid && !in_stall;

	// control: busy flag and sample index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (final_issue) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q && adv) begin
			step_q <= step_q + step_t'(1);
		end
	end

	// segment latch
	always_ff @(posedge clk) begin
		if (accept) begin
			seg_q <= seg_in;
		end
	end

	// current sample request
	always_comb begin
		issue.valid = busy_q;
		issue.step  = step_q;
		issue.pts   = seg_q;
	end

	`CBF_ASSERT_NEXT(a_accept_starts, accept, busy_q && step_q == '0, "segment start lost")
	`CBF_ASSERT_NEXT(a_final_ends, final_issue && !accept, !busy_q, "segment did not end")
	`CBF_ASSERT_NEXT(a_hold_on_stall, busy_q && !adv, busy_q && $stable(step_q),
		"sample index moved while stalled")

endmodule

// ===== hdl/cbf_casteljau.sv =====
// three-stage de casteljau interpolation pipeline, the last stage being the output register
`timescale 1ns / 1ps
module cbf_casteljau (
	input  logic             clk,
	input  logic             arst_n,
	input  cbf_pkg::issue_t  issue,
	input  logic             adv,
	output logic             out_valid,
	output cbf_pkg::coord_t  out_x,
	output cbf_pkg::coord_t  out_y,
	output logic             last_point
);
	import cbf_pkg::*;

	logic         valid_s1;
	logic         valid_s2;
	logic         valid_s3;
	step_t        step_s1;
	step_t        step_s2;
	point_t [2:0] q_s1;
	point_t [1:0] r_s2;
	point_t       p_s3;
	logic         last_s3;

	// valid bits, all stages move together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// first level: three lerps over the control polygon
	always_ff @(posedge clk) begin
		if (adv) begin
			step_s1 <= issue.step;
			for (int i = 0; i < 3; i++) begin
				q_s1[i] <= lerp_pt(issue.pts[i], issue.pts[i+1], issue.step);
			end
		end
	end

	// second level: two lerps
	always_ff @(posedge clk) begin
		if (adv) begin
			step_s2 <= step_s1;
			for (int i = 0; i < 2; i++) begin
				r_s2[i] <= lerp_pt(q_s1[i], q_s1[i+1], step_s1);
			end
		end
	end

	// third level: curve point, held as the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3    <= lerp_pt(r_s2[0], r_s2[1], step_s2);
			last_s3 <= (step_s2 == LAST_STEP);
		end
	end

	assign out_valid  = valid_s3;
	assign out_x      = p_s3.x;
	assign out_y      = p_s3.y;
	assign last_point = last_s3;

endmodule
